FILE: rtl/oss_pkg.sv
// Package for the oversampled sample statistics block.
// Holds field widths, scaling constants and the batch hand-over struct.
// No dependencies; every other file refers to it by scoped names.
package oss_pkg;

    localparam int SAMPLE_BITS     = 12;
    localparam int COUNT_BITS      = 16;
    localparam int CFG_BITS        = 16;
    localparam int N_BITS          = COUNT_BITS + 1;
    localparam int SUM_BITS        = 28;
    localparam int SQ_BITS         = 40;
    localparam int SQR_BITS        = 2 * SAMPLE_BITS;
    localparam int VAR_BITS        = 2 * SAMPLE_BITS;
    localparam int ROOT_BITS       = VAR_BITS / 2;
    localparam int UV_BITS         = 22;
    localparam int PROD_BITS       = 34;
    localparam int DIV_BITS        = SQ_BITS;
    localparam int DIV_CNT_BITS    = $clog2(DIV_BITS);
    localparam int ROOT_CNT_BITS   = $clog2(ROOT_BITS);

    localparam int FULL_SCALE_UV   = 3300000;
    localparam int ROUND_HALF      = 2048;
    localparam int FULL_SCALE_CODE = 4095;
    localparam int COUNT_RESET     = 64;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [UV_BITS-1:0]     uv_t;

    // Totals of one closed batch, handed from the accumulator to the finisher
    typedef struct packed {
        sample_t             min_val;
        sample_t             max_val;
        logic [SUM_BITS-1:0] sum;
        logic [SQ_BITS-1:0]  sum_sq;
        logic [N_BITS-1:0]   n;
    } batch_t;

endpackage

FILE: rtl/oss_if.sv
// Channel interfaces of the oversampled sample statistics block.
// Depends on oss_pkg for the payload widths.
interface oss_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [oss_pkg::CFG_BITS-1:0]  sample_count;

    modport source (output valid, output sample_count, input ready);
    modport sink (input valid, input sample_count, output ready);
endinterface

interface oss_sample_if;
    logic             valid;
    logic             ready;
    oss_pkg::sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface oss_result_if;
    logic             valid;
    logic             ready;
    oss_pkg::sample_t min_counts;
    oss_pkg::sample_t max_counts;
    oss_pkg::sample_t mean_counts;
    oss_pkg::sample_t stddev_counts;
    oss_pkg::uv_t     min_microvolts;
    oss_pkg::uv_t     max_microvolts;
    oss_pkg::uv_t     mean_microvolts;
    oss_pkg::uv_t     stddev_microvolts;

    modport source (output valid, output min_counts, output max_counts, output mean_counts,
                    output stddev_counts, output min_microvolts, output max_microvolts,
                    output mean_microvolts, output stddev_microvolts, input ready);
    modport sink (input valid, input min_counts, input max_counts, input mean_counts,
                  input stddev_counts, input min_microvolts, input max_microvolts,
                  input mean_microvolts, input stddev_microvolts, output ready);
endinterface

FILE: rtl/oss_accum.sv
// Batch accumulator: running minimum, maximum, sum and sum of squares.
// Holds the batch length register. Depends on oss_pkg and oss_if.
module oss_accum (
    input  logic                 clk,
    input  logic                 rst_n,
    oss_cfg_if.sink              cfg,
    oss_sample_if.sink           samples,
    input  logic                 fin_busy,
    output oss_pkg::batch_t      batch,
    output logic                 batch_valid
);

    logic [oss_pkg::COUNT_BITS-1:0] count_reg;
    logic [oss_pkg::COUNT_BITS-1:0] seen_reg;
    oss_pkg::sample_t               min_reg;
    oss_pkg::sample_t               max_reg;
    logic [oss_pkg::SUM_BITS-1:0]   sum_reg;
    logic [oss_pkg::SQ_BITS-1:0]    sq_reg;
    oss_pkg::batch_t                batch_reg;
    logic                           batch_valid_reg;

    logic [oss_pkg::COUNT_BITS-1:0] seen_next;
    logic [oss_pkg::COUNT_BITS-1:0] target;
    logic                           closes;
    logic                           take;
    oss_pkg::sample_t               min_next;
    oss_pkg::sample_t               max_next;
    logic [oss_pkg::SUM_BITS-1:0]   sum_next;
    logic [oss_pkg::SQ_BITS-1:0]    sq_next;
    logic [oss_pkg::SQR_BITS-1:0]   s_sq;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        seen_next = seen_reg + 1'b1;
        target    = (count_reg == '0) ? oss_pkg::COUNT_BITS'(1) : count_reg;
        // a wrapped count means a full batch of 2^COUNT_BITS samples
        closes    = (seen_next == '0) || (seen_next >= target);
        // stall only the sample that would close a batch while the finisher is occupied
        samples.ready = !((fin_busy || batch_valid_reg) && closes);
        take      = samples.valid && samples.ready;
        min_next  = (samples.sample < min_reg) ? samples.sample : min_reg;
        max_next  = (samples.sample > max_reg) ? samples.sample : max_reg;
        s_sq      = samples.sample * samples.sample;
        sum_next  = sum_reg + oss_pkg::SUM_BITS'(samples.sample);
        sq_next   = sq_reg + oss_pkg::SQ_BITS'(s_sq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= oss_pkg::COUNT_BITS'(oss_pkg::COUNT_RESET);
            seen_reg        <= '0;
            min_reg         <= '1;
            max_reg         <= '0;
            sum_reg         <= '0;
            sq_reg          <= '0;
            batch_reg       <= '0;
            batch_valid_reg <= 1'b0;
        end
        else
        begin
            batch_valid_reg <= take && closes;
            if (cfg.valid)
            begin
                count_reg <= cfg.sample_count[oss_pkg::COUNT_BITS-1:0];
            end
            if (take)
            begin
                if (closes)
                begin
                    batch_reg.min_val <= min_next;
                    batch_reg.max_val <= max_next;
                    batch_reg.sum     <= sum_next;
                    batch_reg.sum_sq  <= sq_next;
                    batch_reg.n       <= (seen_next == '0) ? {1'b1, seen_next}
                                                           : {1'b0, seen_next};
                    seen_reg          <= '0;
                    min_reg           <= '1;
                    max_reg           <= '0;
                    sum_reg           <= '0;
                    sq_reg            <= '0;
                end
                else
                begin
                    seen_reg <= seen_next;
                    min_reg  <= min_next;
                    max_reg  <= max_next;
                    sum_reg  <= sum_next;
                    sq_reg   <= sq_next;
                end
            end
        end
    end

    assign batch       = batch_reg;
    assign batch_valid = batch_valid_reg;

endmodule

FILE: rtl/oss_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Shared by the mean, the mean square and the microvolt scaling. Depends on oss_pkg.
module oss_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [oss_pkg::DIV_BITS-1:0]  num,
    input  logic [oss_pkg::N_BITS-1:0]    den,
    output logic                          done,
    output logic [oss_pkg::DIV_BITS-1:0]  quot
);

    logic [oss_pkg::DIV_BITS-1:0]     acc_reg;
    logic [oss_pkg::N_BITS-1:0]       rem_reg;
    logic [oss_pkg::N_BITS-1:0]       den_reg;
    logic [oss_pkg::DIV_CNT_BITS-1:0] cnt_reg;
    logic                             run_reg;
    logic                             done_reg;

    logic [oss_pkg::N_BITS:0]         rem_sh;
    logic                             fits;
    logic [oss_pkg::N_BITS-1:0]       rem_next;
    logic [oss_pkg::DIV_BITS-1:0]     acc_next;
    logic                             last;

    always_comb
    begin
        // bring down the next dividend bit, subtract when the divisor fits
        rem_sh   = {rem_reg, acc_reg[oss_pkg::DIV_BITS-1]};
        fits     = rem_sh >= {1'b0, den_reg};
        rem_next = fits ? oss_pkg::N_BITS'(rem_sh - {1'b0, den_reg})
                        : oss_pkg::N_BITS'(rem_sh);
        acc_next = {acc_reg[oss_pkg::DIV_BITS-2:0], fits};
        last     = (cnt_reg == oss_pkg::DIV_CNT_BITS'(oss_pkg::DIV_BITS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && run_reg && last;
            if (start)
            begin
                acc_reg <= num;
                rem_reg <= '0;
                den_reg <= den;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                acc_reg <= acc_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = acc_reg;

endmodule

FILE: rtl/oss_sqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
// Gives the floor root of the variance. Depends on oss_pkg.
module oss_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [oss_pkg::VAR_BITS-1:0]  radicand,
    output logic                          done,
    output logic [oss_pkg::ROOT_BITS-1:0] root
);

    logic [oss_pkg::VAR_BITS-1:0]      rad_reg;
    logic [oss_pkg::ROOT_BITS+1:0]     rem_reg;
    logic [oss_pkg::ROOT_BITS-1:0]     root_reg;
    logic [oss_pkg::ROOT_CNT_BITS-1:0] cnt_reg;
    logic                              run_reg;
    logic                              done_reg;

    logic [oss_pkg::ROOT_BITS+3:0]     rem_sh;
    logic [oss_pkg::ROOT_BITS+3:0]     trial;
    logic                              fits;
    logic                              last;

    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[oss_pkg::VAR_BITS-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        fits   = rem_sh >= trial;
        last   = (cnt_reg == oss_pkg::ROOT_CNT_BITS'(oss_pkg::ROOT_BITS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && run_reg && last;
            if (start)
            begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
                run_reg  <= 1'b1;
            end
            else if (run_reg)
            begin
                rad_reg  <= {rad_reg[oss_pkg::VAR_BITS-3:0], 2'b00};
                rem_reg  <= fits ? (oss_pkg::ROOT_BITS + 2)'(rem_sh - trial)
                                 : (oss_pkg::ROOT_BITS + 2)'(rem_sh);
                root_reg <= {root_reg[oss_pkg::ROOT_BITS-2:0], fits};
                cnt_reg  <= cnt_reg + 1'b1;
                if (last)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: rtl/oss_finish.sv
// Batch finisher: sequences mean, variance, root and microvolt scaling
// over the shared divider and root unit, and holds the result register.
// Depends on oss_pkg, oss_if, oss_div and oss_sqrt.
module oss_finish (
    input  logic            clk,
    input  logic            rst_n,
    input  oss_pkg::batch_t batch,
    input  logic            batch_valid,
    output logic            busy,
    oss_result_if.source    results
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN,
        ST_MEAN_W,
        ST_QUOT,
        ST_QUOT_W,
        ST_ROOT,
        ST_ROOT_W,
        ST_MUL,
        ST_UV,
        ST_UV_W,
        ST_OUT
    } state_t;

    state_t                          state_reg;
    oss_pkg::batch_t                 batch_reg;
    oss_pkg::sample_t                mean_reg;
    logic [oss_pkg::VAR_BITS-1:0]    msq_reg;
    logic [oss_pkg::VAR_BITS-1:0]    var_reg;
    oss_pkg::sample_t                dev_reg;
    logic [oss_pkg::PROD_BITS-1:0]   prod_reg;
    logic [1:0]                      idx_reg;
    oss_pkg::uv_t                    uv_reg [4];
    logic                            out_valid_reg;
    oss_pkg::sample_t                out_min_reg;
    oss_pkg::sample_t                out_max_reg;
    oss_pkg::sample_t                out_mean_reg;
    oss_pkg::sample_t                out_dev_reg;
    oss_pkg::uv_t                    out_min_uv_reg;
    oss_pkg::uv_t                    out_max_uv_reg;
    oss_pkg::uv_t                    out_mean_uv_reg;
    oss_pkg::uv_t                    out_dev_uv_reg;

    logic                            div_start;
    logic [oss_pkg::DIV_BITS-1:0]    div_num;
    logic [oss_pkg::N_BITS-1:0]      div_den;
    logic                            div_done;
    logic [oss_pkg::DIV_BITS-1:0]    div_quot;
    logic                            sqrt_start;
    logic                            sqrt_done;
    logic [oss_pkg::ROOT_BITS-1:0]   sqrt_root;
    logic [oss_pkg::VAR_BITS-1:0]    q_low;
    oss_pkg::sample_t                cnt_sel;

    oss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    oss_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (var_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_comb
    begin
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = batch_reg.n;
        sqrt_start = (state_reg == ST_ROOT);
        case (state_reg)
            ST_MEAN:
            begin
                div_start = 1'b1;
                div_num   = oss_pkg::DIV_BITS'(batch_reg.sum)
                          + oss_pkg::DIV_BITS'(batch_reg.n >> 1);
            end
            ST_QUOT:
            begin
                div_start = 1'b1;
                div_num   = batch_reg.sum_sq;
            end
            ST_UV:
            begin
                div_start = 1'b1;
                div_num   = oss_pkg::DIV_BITS'(prod_reg);
                div_den   = oss_pkg::N_BITS'(oss_pkg::FULL_SCALE_CODE);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase

        // sum of squares over n never exceeds the largest sample squared
        q_low = div_quot[oss_pkg::VAR_BITS-1:0];

        case (idx_reg)
            2'd0:    cnt_sel = batch_reg.min_val;
            2'd1:    cnt_sel = batch_reg.max_val;
            2'd2:    cnt_sel = mean_reg;
            default: cnt_sel = dev_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            batch_reg       <= '0;
            mean_reg        <= '0;
            msq_reg         <= '0;
            var_reg         <= '0;
            dev_reg         <= '0;
            prod_reg        <= '0;
            idx_reg         <= '0;
            uv_reg          <= '{default: '0};
            out_valid_reg   <= 1'b0;
            out_min_reg     <= '0;
            out_max_reg     <= '0;
            out_mean_reg    <= '0;
            out_dev_reg     <= '0;
            out_min_uv_reg  <= '0;
            out_max_uv_reg  <= '0;
            out_mean_uv_reg <= '0;
            out_dev_uv_reg  <= '0;
        end
        else
        begin
            // ST_OUT reloads the result register itself
            if (out_valid_reg && results.ready && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (batch_valid)
                    begin
                        batch_reg <= batch;
                        state_reg <= ST_MEAN;
                    end
                end
                ST_MEAN:
                begin
                    state_reg <= ST_MEAN_W;
                end
                ST_MEAN_W:
                begin
                    if (div_done)
                    begin
                        mean_reg  <= div_quot[oss_pkg::SAMPLE_BITS-1:0];
                        state_reg <= ST_QUOT;
                    end
                end
                ST_QUOT:
                begin
                    msq_reg   <= mean_reg * mean_reg;
                    state_reg <= ST_QUOT_W;
                end
                ST_QUOT_W:
                begin
                    if (div_done)
                    begin
                        var_reg   <= (q_low > msq_reg) ? q_low - msq_reg : '0;
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    state_reg <= ST_ROOT_W;
                end
                ST_ROOT_W:
                begin
                    if (sqrt_done)
                    begin
                        dev_reg   <= oss_pkg::SAMPLE_BITS'(sqrt_root);
                        idx_reg   <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= oss_pkg::PROD_BITS'(cnt_sel)
                               * oss_pkg::PROD_BITS'(oss_pkg::FULL_SCALE_UV)
                               + oss_pkg::PROD_BITS'(oss_pkg::ROUND_HALF);
                    state_reg <= ST_UV;
                end
                ST_UV:
                begin
                    state_reg <= ST_UV_W;
                end
                ST_UV_W:
                begin
                    if (div_done)
                    begin
                        uv_reg[idx_reg] <= div_quot[oss_pkg::UV_BITS-1:0];
                        idx_reg         <= idx_reg + 1'b1;
                        state_reg       <= (idx_reg == 2'd3) ? ST_OUT : ST_MUL;
                    end
                end
                ST_OUT:
                begin
                    // hold here until the result register is free
                    if (!out_valid_reg || results.ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_min_reg     <= batch_reg.min_val;
                        out_max_reg     <= batch_reg.max_val;
                        out_mean_reg    <= mean_reg;
                        out_dev_reg     <= dev_reg;
                        out_min_uv_reg  <= uv_reg[0];
                        out_max_uv_reg  <= uv_reg[1];
                        out_mean_uv_reg <= uv_reg[2];
                        out_dev_uv_reg  <= uv_reg[3];
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy                      = (state_reg != ST_IDLE);
    assign results.valid             = out_valid_reg;
    assign results.min_counts        = out_min_reg;
    assign results.max_counts        = out_max_reg;
    assign results.mean_counts       = out_mean_reg;
    assign results.stddev_counts     = out_dev_reg;
    assign results.min_microvolts    = out_min_uv_reg;
    assign results.max_microvolts    = out_max_uv_reg;
    assign results.mean_microvolts   = out_mean_uv_reg;
    assign results.stddev_microvolts = out_dev_uv_reg;

    a_batch_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        batch_valid |-> state_reg == ST_IDLE)
        else $error("batch handed over while finisher busy");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_MEAN_W || state_reg == ST_QUOT_W
                      || state_reg == ST_UV_W))
        else $error("divider finished outside a wait state");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.min_counts <= results.max_counts)
        else $error("result minimum above maximum");

    a_uv_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.max_microvolts <= oss_pkg::UV_BITS'(oss_pkg::FULL_SCALE_UV)
                           && results.stddev_microvolts
                              <= oss_pkg::UV_BITS'(oss_pkg::FULL_SCALE_UV)))
        else $error("scaled value beyond full scale");

endmodule

FILE: rtl/oversampled_sample_statistics.sv
// Oversampled sample statistics: min, max, mean and deviation per batch.
// Depends on oss_pkg, oss_if, oss_accum and oss_finish.
//
// Channels: cfg writes the batch length (0 counts as 1, reset value 64) and
// is always ready; write it only while the block is idle. samples takes one
// 12-bit sample per transfer, results gives one transfer per closed batch.
// Throughput: one sample per cycle. The sample that closes a batch is held
// off while the previous batch is still in the finisher.
// After the closing sample the finisher runs the bit-serial divider for the mean
// and the mean square, then the square root, then the divider again for four
// microvolt scalings: six divider passes in all, with sequencing states between.
// Batches that close faster than the finisher therefore run at one per finishing time.
// The result is held in an output register until taken; while it waits the
// next batch is still gathered and finished, and only the hand-over stalls.
// Reset: accumulators clear, batch length returns to 64, no result pending.
module oversampled_sample_statistics (
    input  logic          clk,
    input  logic          rst_n,
    oss_cfg_if.sink       cfg,
    oss_sample_if.sink    samples,
    oss_result_if.source  results
);

    oss_pkg::batch_t batch;
    logic            batch_valid;
    logic            fin_busy;

    oss_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .samples     (samples),
        .fin_busy    (fin_busy),
        .batch       (batch),
        .batch_valid (batch_valid)
    );

    oss_finish u_finish (
        .clk         (clk),
        .rst_n       (rst_n),
        .batch       (batch),
        .batch_valid (batch_valid),
        .busy        (fin_busy),
        .results     (results)
    );

endmodule

FILE: dv/oss_stats_checker.sv
// Checker for the oversampled sample statistics block: watches the three channels,
// predicts each batch result and compares it with what the block hands out.
// Depends on oss_pkg and the channel interfaces in oss_if.
module oss_stats_checker (
    input  logic   clk,
    input  logic   rst_n,
    oss_cfg_if     cfg,
    oss_sample_if  samples,
    oss_result_if  results,
    output int     mismatches,
    output int     stats_due,
    output int     stats_checked,
    output int     samples_taken
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        oss_pkg::sample_t min_counts;
        oss_pkg::sample_t max_counts;
        oss_pkg::sample_t mean_counts;
        oss_pkg::sample_t stddev_counts;
        oss_pkg::uv_t     min_microvolts;
        oss_pkg::uv_t     max_microvolts;
        oss_pkg::uv_t     mean_microvolts;
        oss_pkg::uv_t     stddev_microvolts;
    } batch_stats_t;

    logic [oss_pkg::CFG_BITS-1:0]   batch_len;
    logic [oss_pkg::COUNT_BITS-1:0] gathered;
    oss_pkg::sample_t               lowest;
    oss_pkg::sample_t               highest;
    logic [oss_pkg::SUM_BITS-1:0]   total;
    logic [oss_pkg::SQ_BITS-1:0]    total_sq;
    batch_stats_t                   due_stats[$];
    int                             errs = 0;
    int                             checked = 0;
    int                             taken = 0;

    function automatic void clear_batch();
        gathered = '0;
        lowest   = '1;
        highest  = '0;
        total    = '0;
        total_sq = '0;
    endfunction

    // Bitwise search, the root never exceeds 13 bits here
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int b = 12; b >= 0; b--)
        begin
            trial = r | (64'd1 << b);
            if (trial * trial <= v)
                r = trial;
        end
        return r;
    endfunction

    function automatic oss_pkg::uv_t to_microvolts(longint unsigned c);
        return oss_pkg::uv_t'((c * oss_pkg::FULL_SCALE_UV + oss_pkg::ROUND_HALF)
                              / oss_pkg::FULL_SCALE_CODE);
    endfunction

    // Fold one sample into the batch; returns 1 with the statistics when it closes it
    function automatic bit absorb_sample(input oss_pkg::sample_t s, output batch_stats_t st);
        longint unsigned                target;
        longint unsigned                n;
        longint unsigned                mean;
        longint unsigned                msq;
        longint unsigned                q;
        longint unsigned                vr;
        longint unsigned                dev;
        logic [oss_pkg::COUNT_BITS-1:0] next_seen;
        st = '0;
        target = (batch_len == 0) ? 64'd1 : 64'(batch_len);
        if (s < lowest)
            lowest = s;
        if (s > highest)
            highest = s;
        total     = total + oss_pkg::SUM_BITS'(s);
        total_sq  = total_sq + oss_pkg::SQ_BITS'(s) * oss_pkg::SQ_BITS'(s);
        next_seen = gathered + 1'b1;
        gathered  = next_seen;
        if (next_seen != 0 && next_seen < target)
            return 1'b0;

        n    = (next_seen == 0) ? (64'd1 << oss_pkg::COUNT_BITS) : 64'(next_seen);
        mean = (n == 1) ? 64'(total) : (total + n / 2) / n;
        msq  = mean * mean;
        q    = total_sq / n;
        vr   = (q > msq) ? q - msq : 0;
        dev  = (vr > 0) ? floor_root(vr) : 0;

        st.min_counts        = lowest;
        st.max_counts        = highest;
        st.mean_counts       = oss_pkg::sample_t'(mean);
        st.stddev_counts     = oss_pkg::sample_t'(dev);
        st.min_microvolts    = to_microvolts(lowest);
        st.max_microvolts    = to_microvolts(highest);
        st.mean_microvolts   = to_microvolts(mean);
        st.stddev_microvolts = to_microvolts(dev);
        clear_batch();
        return 1'b1;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errs++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        batch_stats_t st;
        batch_stats_t want;
        if (!rst_n)
        begin
            batch_len = oss_pkg::CFG_BITS'(oss_pkg::COUNT_RESET);
            clear_batch();
            due_stats.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                batch_len = cfg.sample_count;
            if (samples.valid && samples.ready)
            begin
                taken++;
                if (absorb_sample(samples.sample, st))
                    due_stats.push_back(st);
            end
            if (results.valid && results.ready)
            begin
                if (due_stats.size() == 0)
                begin
                    $error("result transfer with no closed batch waiting");
                    errs++;
                end
                else
                begin
                    want = due_stats.pop_front();
                    check_field("min_counts", want.min_counts, results.min_counts);
                    check_field("max_counts", want.max_counts, results.max_counts);
                    check_field("mean_counts", want.mean_counts, results.mean_counts);
                    check_field("stddev_counts", want.stddev_counts, results.stddev_counts);
                    check_field("min_microvolts", want.min_microvolts,
                                results.min_microvolts);
                    check_field("max_microvolts", want.max_microvolts,
                                results.max_microvolts);
                    check_field("mean_microvolts", want.mean_microvolts,
                                results.mean_microvolts);
                    check_field("stddev_microvolts", want.stddev_microvolts,
                                results.stddev_microvolts);
                    checked++;
                end
            end
        end
        // Publish after the edge so the stimulus side never races the update
        mismatches    <= errs;
        stats_due     <= due_stats.size();
        stats_checked <= checked;
        samples_taken <= taken;
    end

endmodule

FILE: dv/oversampled_sample_statistics_tb.sv
// Testbench top for the oversampled sample statistics block: clock, reset,
// batch length writes, sample stimulus, result back-pressure and the verdict.
// Depends on oss_pkg, oss_if, the block itself and oss_stats_checker.
module oversampled_sample_statistics_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 300;
    localparam int MAX_LEN       = (1 << oss_pkg::CFG_BITS) - 1;

    typedef enum {SPREAD_NARROW, SPREAD_RAILS, SPREAD_FLAT, SPREAD_FULL} spread_t;

    logic clk = 1'b0;
    logic rst_n;

    always #2 clk = ~clk;

    oss_cfg_if    cfg_ch();
    oss_sample_if sample_ch();
    oss_result_if result_ch();

    int mismatches;
    int stats_due;
    int stats_checked;
    int samples_taken;

    oversampled_sample_statistics dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .samples (sample_ch),
        .results (result_ch)
    );

    oss_stats_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_ch),
        .samples       (sample_ch),
        .results       (result_ch),
        .mismatches    (mismatches),
        .stats_due     (stats_due),
        .stats_checked (stats_checked),
        .samples_taken (samples_taken)
    );

    int          burst_left = 0;
    bit          steady = 1'b0;
    int          settings = 0;
    int          quiet = 0;
    logic [5:0]  hold_left;
    logic [15:0] tick;

    // Result side: stalls of random length, enabled only while bit 9 of the tick counter is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_left       <= '0;
            tick            <= '0;
        end
        else
        begin
            tick <= tick + 1'b1;
            if (hold_left != 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left       <= hold_left - 1'b1;
            end
            else if (tick[9] && $urandom_range(0, 7) == 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left       <= 6'($urandom_range(0, 39));
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cfg_ch.valid && cfg_ch.ready) || (sample_ch.valid && sample_ch.ready)
            || (result_ch.valid && result_ch.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet == QUIET_LIMIT)
        begin
            $error("no transfer for %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_length(input int len);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.sample_count <= oss_pkg::CFG_BITS'(len);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        settings++;
    endtask

    // Drop valid and hold until every closed batch has been delivered
    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (stats_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_sample(input oss_pkg::sample_t s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = steady ? 1000 : int'($urandom_range(1, 24));
            gap = steady ? 0 : int'($urandom_range(0, 12));
            if (gap != 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        burst_left--;
    endtask

    function automatic oss_pkg::sample_t pick_sample(spread_t spread,
                                                     oss_pkg::sample_t centre);
        int v;
        case (spread)
            SPREAD_NARROW:
            begin
                v = int'(centre) + int'($urandom_range(0, 30)) - 15;
                if (v < 0)
                    v = 0;
                if (v > 4095)
                    v = 4095;
                return oss_pkg::sample_t'(v);
            end
            SPREAD_RAILS: return ($urandom_range(0, 1) != 0) ? '1 : '0;
            SPREAD_FLAT:  return centre;
            default:      return oss_pkg::sample_t'($urandom_range(0, 4095));
        endcase
    endfunction

    initial
    begin
        int               sent;
        int               pick;
        int               eff;
        int               items;
        int               len;
        spread_t          spread;
        oss_pkg::sample_t centre;

        rst_n                = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.sample_count  = '0;
        sample_ch.valid      = 1'b0;
        sample_ch.sample     = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Partial batch under the reset length, then shorten it below what is gathered
        push_sample(12'hFFF);
        push_sample(12'h000);
        push_sample(12'h800);
        settle();
        write_length(1);
        push_sample(12'h001);
        push_sample(12'hFFF);
        push_sample(12'h000);
        // Zero length behaves as one
        settle();
        write_length(0);
        push_sample(12'hFFF);
        push_sample(12'hAAA);
        push_sample(12'h555);
        // Widest spread, then no spread at all
        settle();
        write_length(2);
        push_sample(12'h000);
        push_sample(12'hFFF);
        push_sample(12'hFFF);
        push_sample(12'hFFF);
        // Longest length, cut short after a few samples
        settle();
        write_length(MAX_LEN);
        repeat (4) push_sample(12'hFFF);
        push_sample(12'h000);
        push_sample(12'h7FF);
        settle();
        write_length(3);
        push_sample(12'h000);
        settle();
        write_length(5);
        for (int i = 0; i < 5; i++)
            push_sample(oss_pkg::sample_t'(100 + i));

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                len = int'($urandom_range(1, 16));
            else if (pick < 80)
                len = int'($urandom_range(17, 64));
            else if (pick < 90)
                len = int'($urandom_range(65, 300));
            else if (pick < 94)
                len = 0;
            else if (pick < 97)
                len = 1;
            else
                len = MAX_LEN;
            eff = (len == 0) ? 1 : len;
            // Leftover samples carry into the next setting, often a shorter one
            if (len == MAX_LEN)
                items = int'($urandom_range(1, 40));
            else if (eff > 64)
                items = eff + int'($urandom_range(0, eff - 1));
            else
                items = eff * int'($urandom_range(1, 4)) + int'($urandom_range(0, eff - 1));
            pick   = $urandom_range(0, 5);
            spread = (pick > 3) ? SPREAD_FULL : spread_t'(pick);
            centre = oss_pkg::sample_t'($urandom_range(0, 4095));
            steady = ($urandom_range(0, 3) == 0);
            burst_left = 0;
            settle();
            write_length(len);
            repeat (items)
            begin
                push_sample(pick_sample(spread, centre));
                sent++;
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d batch results from %0d samples over %0d length settings,",
                 stats_checked, samples_taken, settings);
        $display("lengths from zero to the maximum, with stalls on both channels.");
        if (mismatches == 0 && stats_due == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            if (stats_due != 0)
                $error("%0d batch results never arrived", stats_due);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
